// ----- sv/sprt_pkg.sv -----
// Package for the source prefix route table: sizes, codes and shared types.
// Used by the interfaces, controller, datapath and top level.
`default_nettype none
package sprt_pkg;
	localparam int MaxRules = 16;
	localparam int IdxW = $clog2(MaxRules);
	localparam int CntW = $clog2(MaxRules + 1);
	localparam logic [15:0] MtuEmpty = 16'hffff;

	localparam logic [1:0] ACT_LOOKUP = 2'd0;
	localparam logic [1:0] ACT_SET    = 2'd1;
	localparam logic [1:0] ACT_DELETE = 2'd2;
	localparam logic [1:0] ACT_SPARE  = 2'd3;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_NO_MATCH = 3'd1;
	localparam logic [2:0] ST_BAD_IDX  = 3'd2;
	localparam logic [2:0] ST_BAD_PLEN = 3'd3;
	localparam logic [2:0] ST_FULL     = 3'd4;

	localparam logic [0:0] REG_MTU_LOCKED = 1'd0;

	typedef struct packed {
		logic [1:0]  action;
		logic        is_ipv6;
		logic [63:0] address_high;
		logic [63:0] address_low;
		logic [4:0]  rule_index;
		logic [7:0]  prefix_length;
		logic [7:0]  dest_port;
		logic [15:0] dest_mtu;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic        hit;
		logic [3:0]  matched_index;
		logic [7:0]  matched_port;
		logic [4:0]  rule_count;
		logic [15:0] path_mtu;
	} rsp_t;

	// Controller to datapath.
	typedef struct packed {
		logic            load;      // capture request, clear hit flag
		logic            write;     // write rule at request index
		logic            shift;     // copy entry ptr+1 to ptr
		logic            scan;      // examine entry at ptr for a match
		logic            mtu_init;  // start minimum search
		logic            mtu_step;  // fold entry at ptr into minimum
		logic            mtu_commit;
		logic            cnt_inc;
		logic            cnt_dec;
		logic            ptr_clr;
		logic            ptr_inc;
		logic            ptr_from_idx;
		logic            finish;    // load the output word
		logic [2:0]      status;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic [1:0] action;
		logic       idx_gt_cnt;
		logic       idx_ge_cnt;
		logic       plen_bad;
		logic       full_append;
		logic       ptr_last;    // ptr+1 >= count
		logic       ptr_end;     // ptr >= count
		logic       match;
	} sts_t;
endpackage
`default_nettype wire

// ----- sv/sprt_if.sv -----
// Valid/ready channel interfaces for requests and responses.
// Depends on sprt_pkg.
`default_nettype none
interface sprt_req_if;
	logic valid;
	logic ready;
	sprt_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface sprt_rsp_if;
	logic valid;
	logic ready;
	sprt_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- sv/sprt_ctrl.sv -----
// Controller state machine for the route table: sequences lookup, set,
// delete and MTU walks. Depends on sprt_pkg.
`default_nettype none
module sprt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  wire logic           out_ready,
	input  wire logic           mtu_locked,
	input  wire sprt_pkg::sts_t sts,
	output sprt_pkg::cmd_t      cmd
);
	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_DECODE = 7'b0000010,
		S_SCAN   = 7'b0000100,
		S_SHIFT  = 7'b0001000,
		S_MTU    = 7'b0010000,
		S_FINISH = 7'b0100000,
		S_OUT    = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [2:0] status_q, status_d;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);

	always_comb begin
		state_d = state_q;
		status_d = status_q;
		cmd = '0;
		cmd.status = status_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				status_d = sprt_pkg::ST_OK;
				state_d = S_FINISH;
				case (sts.action)
					sprt_pkg::ACT_LOOKUP: begin
						status_d = sprt_pkg::ST_NO_MATCH;
						cmd.ptr_clr = 1'b1;
						state_d = S_SCAN;
					end
					sprt_pkg::ACT_SET: begin
						if (sts.idx_gt_cnt) status_d = sprt_pkg::ST_BAD_IDX;
						else if (sts.plen_bad) status_d = sprt_pkg::ST_BAD_PLEN;
						else if (sts.full_append) status_d = sprt_pkg::ST_FULL;
						else begin
							cmd.write = 1'b1;
							cmd.cnt_inc = sts.idx_ge_cnt;
							if (!mtu_locked) begin
								cmd.ptr_clr = 1'b1;
								cmd.mtu_init = 1'b1;
								state_d = S_MTU;
							end
						end
					end
					sprt_pkg::ACT_DELETE: begin
						if (sts.idx_ge_cnt) status_d = sprt_pkg::ST_BAD_IDX;
						else begin
							cmd.ptr_from_idx = 1'b1;
							state_d = S_SHIFT;
						end
					end
					default: ;
				endcase
			end
			S_SCAN: begin
				if (sts.ptr_end) state_d = S_FINISH;
				else begin
					cmd.scan = 1'b1;
					if (sts.match) begin
						status_d = sprt_pkg::ST_OK;
						state_d = S_FINISH;
					end else cmd.ptr_inc = 1'b1;
				end
			end
			S_SHIFT: begin
				if (sts.ptr_last) begin
					cmd.cnt_dec = 1'b1;
					if (mtu_locked) state_d = S_FINISH;
					else begin
						cmd.ptr_clr = 1'b1;
						cmd.mtu_init = 1'b1;
						state_d = S_MTU;
					end
				end else begin
					cmd.shift = 1'b1;
					cmd.ptr_inc = 1'b1;
				end
			end
			S_MTU: begin
				if (sts.ptr_end) begin
					cmd.mtu_commit = 1'b1;
					state_d = S_FINISH;
				end else begin
					cmd.mtu_step = 1'b1;
					cmd.ptr_inc = 1'b1;
				end
			end
			S_FINISH: begin
				cmd.finish = 1'b1;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= sprt_pkg::ST_OK;
		end else begin
			state_q <= state_d;
			status_q <= status_d;
		end
	end
endmodule
`default_nettype wire

// ----- sv/sprt_dp.sv -----
// Datapath for the route table: rule storage, walk pointer, matcher,
// MTU minimum and output register. Depends on sprt_pkg.
`default_nettype none
module sprt_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sprt_pkg::req_t req,
	input  wire sprt_pkg::cmd_t cmd,
	output sprt_pkg::sts_t      sts,
	output sprt_pkg::rsp_t      rsp
);
	localparam int Iw = sprt_pkg::IdxW;
	localparam int Cw = sprt_pkg::CntW;

	logic [63:0] hi_mem [sprt_pkg::MaxRules];
	logic [63:0] lo_mem [sprt_pkg::MaxRules];
	logic        fam_mem [sprt_pkg::MaxRules];
	logic [7:0]  plen_mem [sprt_pkg::MaxRules];
	logic [7:0]  port_mem [sprt_pkg::MaxRules];
	logic [15:0] mtu_mem [sprt_pkg::MaxRules];

	sprt_pkg::req_t req_q;
	sprt_pkg::rsp_t rsp_q;
	logic [Cw-1:0] cnt_q, ptr_q;
	logic [15:0] path_mtu_q, min_q;
	logic hit_q;
	logic [Iw-1:0] midx_q;
	logic [7:0] mport_q;

	logic [Cw-1:0] idx_c, ptr1;
	logic [Iw-1:0] p, p1, widx;
	logic [7:0] pl;
	logic [63:0] mh, ml, m4;

	assign idx_c = Cw'(req_q.rule_index);
	assign ptr1 = ptr_q + 1'b1;
	assign p = ptr_q[Iw-1:0];
	assign p1 = ptr1[Iw-1:0];
	assign widx = req_q.rule_index[Iw-1:0];
	assign pl = plen_mem[p];

	always_comb begin
		mh = (pl == 8'd0) ? 64'd0 : (pl >= 8'd64) ? '1 : ~64'd0 << (7'd64 - pl[6:0]);
		ml = (pl <= 8'd64) ? 64'd0 : (pl >= 8'd128) ? '1
			: ~64'd0 << (8'd128 - pl);
		m4 = (pl == 8'd0) ? 64'd0 : (pl >= 8'd32) ? 64'hffffffff
			: {32'd0, 32'hffffffff << (6'd32 - pl[5:0])};
	end

	always_comb begin
		sts.action = req_q.action;
		sts.idx_gt_cnt = Cw'(req_q.rule_index) > cnt_q || (|(req_q.rule_index >> Cw));
		sts.idx_ge_cnt = Cw'(req_q.rule_index) >= cnt_q || (|(req_q.rule_index >> Cw));
		sts.plen_bad = req_q.prefix_length > (req_q.is_ipv6 ? 8'd128 : 8'd32);
		sts.full_append = (idx_c == cnt_q) && (cnt_q >= Cw'(sprt_pkg::MaxRules));
		sts.ptr_last = ptr1 >= cnt_q;
		sts.ptr_end = ptr_q >= cnt_q;
		if (fam_mem[p] != req_q.is_ipv6) sts.match = 1'b0;
		else if (!req_q.is_ipv6)
			sts.match = ({32'd0, req_q.address_low[31:0]} & m4) == lo_mem[p];
		else
			sts.match = ((req_q.address_high ^ hi_mem[p]) & mh) == 64'd0
				&& ((req_q.address_low ^ lo_mem[p]) & ml) == 64'd0;
	end

	// Rule storage: one write per cycle, either a set or one shift step.
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			fam_mem[widx] <= req_q.is_ipv6;
			hi_mem[widx] <= req_q.is_ipv6 ? req_q.address_high : 64'd0;
			lo_mem[widx] <= req_q.is_ipv6 ? req_q.address_low
				: {32'd0, req_q.address_low[31:0]};
			plen_mem[widx] <= req_q.prefix_length;
			port_mem[widx] <= req_q.dest_port;
			mtu_mem[widx] <= req_q.dest_mtu;
		end else if (cmd.shift) begin
			fam_mem[p] <= fam_mem[p1];
			hi_mem[p] <= hi_mem[p1];
			lo_mem[p] <= lo_mem[p1];
			plen_mem[p] <= plen_mem[p1];
			port_mem[p] <= port_mem[p1];
			mtu_mem[p] <= mtu_mem[p1];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) req_q <= req;
		if (cmd.mtu_init) min_q <= sprt_pkg::MtuEmpty;
		else if (cmd.mtu_step && mtu_mem[p] < min_q) min_q <= mtu_mem[p];
		if (cmd.scan && sts.match) begin
			midx_q <= p;
			mport_q <= port_mem[p];
		end
		if (cmd.finish) begin
			rsp_q.status <= cmd.status;
			rsp_q.hit <= hit_q;
			rsp_q.matched_index <= hit_q ? 4'(midx_q) : 4'd0;
			rsp_q.matched_port <= hit_q ? mport_q : 8'd0;
			rsp_q.rule_count <= 5'(cnt_q);
			rsp_q.path_mtu <= path_mtu_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ptr_q <= '0;
			path_mtu_q <= sprt_pkg::MtuEmpty;
			hit_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) cnt_q <= cnt_q + 1'b1;
			else if (cmd.cnt_dec) cnt_q <= cnt_q - 1'b1;
			if (cmd.ptr_clr) ptr_q <= '0;
			else if (cmd.ptr_from_idx) ptr_q <= idx_c;
			else if (cmd.ptr_inc) ptr_q <= ptr1;
			if (cmd.mtu_commit) path_mtu_q <= min_q;
			if (cmd.load) hit_q <= 1'b0;
			else if (cmd.scan && sts.match) hit_q <= 1'b1;
		end
	end

	assign rsp = rsp_q;
endmodule
`default_nettype wire

// ----- sv/source_prefix_route_table.sv -----
// Top level of the source prefix route table: APB register, controller and
// datapath. Depends on sprt_pkg, sprt_if, sprt_ctrl and sprt_dp.
//
//   Channel  Dir  Handshake          Word
//   req      in   valid/ready        action, family, address, index, rule
//   rsp      out  valid/ready        status, hit, match, count, path MTU
//   APB      in   psel/penable       mtu_locked at address 0
//
// An item is taken only in idle, then decoded. A lookup walks the rules
// one per cycle until the first match; a delete moves one rule down per
// cycle; a set or delete that succeeds with the lock clear then walks all
// rules once for the minimum MTU. Reset clears the count, the path MTU to
// 65535 and the lock. The result word holds in its register while the sink
// stalls, and no new word is accepted until it is taken.
`default_nettype none
module source_prefix_route_table (
	input  wire logic         clk,
	input  wire logic         arst_n,
	sprt_req_if.sink          req,
	sprt_rsp_if.source        rsp,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [1:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	sprt_pkg::cmd_t cmd;
	sprt_pkg::sts_t sts;
	logic mtu_locked_q;
	logic lock_sel;

	assign pready = 1'b1;
	// Only register 0 exists; other addresses read zero and ignore writes.
	assign lock_sel = (paddr == 2'({sprt_pkg::REG_MTU_LOCKED, 2'b00}));
	assign prdata = lock_sel ? {31'd0, mtu_locked_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) mtu_locked_q <= 1'b0;
		else if (psel && penable && pwrite && lock_sel) begin
			mtu_locked_q <= pwdata[0];
		end
	end

	sprt_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.out_valid  (rsp.valid),
		.out_ready  (rsp.ready),
		.mtu_locked (mtu_locked_q),
		.sts        (sts),
		.cmd        (cmd)
	);

	sprt_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.data),
		.cmd    (cmd),
		.sts    (sts),
		.rsp    (rsp.data)
	);
endmodule
`default_nettype wire

// ----- test/tb.sv -----
// Testbench for source_prefix_route_table: drives request words and APB writes
// and checks every response against an in-bench model of the ordered table.
// Depends on sprt_pkg, sprt_if and the RTL of the block.
`timescale 1ns / 1ps
module tb;
	localparam int ClkPeriod = 12;
	localparam int SettleCycles = 45;
	localparam int LimitCycles = 1500000;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	sprt_req_if req ();
	sprt_rsp_if rsp ();

	source_prefix_route_table dut (
		.clk(clk), .arst_n(arst_n), .req(req), .rsp(rsp),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// Model of the table. Only entries below tbl_count are ever read.
	logic [63:0] tbl_hi [sprt_pkg::MaxRules];
	logic [63:0] tbl_lo [sprt_pkg::MaxRules];
	logic tbl_v6 [sprt_pkg::MaxRules];
	logic [7:0] tbl_plen [sprt_pkg::MaxRules];
	logic [7:0] tbl_port [sprt_pkg::MaxRules];
	logic [15:0] tbl_mtu [sprt_pkg::MaxRules];
	int tbl_count;
	logic [15:0] tbl_path_mtu;
	logic tbl_locked;

	sprt_pkg::rsp_t expected_words [$];
	int n_mismatch;
	bit steady_sink;    // when set, the sink never stalls
	bit steady_source;  // when set, the sender never pauses

	initial begin
		clk = 1'b0;
		forever #(ClkPeriod / 2) clk = ~clk;
	end

	function automatic logic [63:0] top_mask(int len);
		if (len <= 0) return 64'd0;
		if (len >= 64) return '1;
		return ~64'd0 << (64 - len);
	endfunction

	function automatic logic [31:0] v4_mask(int len);
		if (len <= 0) return 32'd0;
		if (len >= 32) return '1;
		return ~32'd0 << (32 - len);
	endfunction

	function automatic bit rule_hit(int k, logic v6, logic [63:0] hi, logic [63:0] lo);
		int p;
		p = tbl_plen[k];
		if (tbl_v6[k] != v6) return 0;
		// An IPv4 rule with stray bits below its prefix can never match.
		if (!v6) return {32'd0, lo[31:0] & v4_mask(p)} == tbl_lo[k];
		return ((hi ^ tbl_hi[k]) & top_mask(p)) == 64'd0 &&
			((lo ^ tbl_lo[k]) & (p > 64 ? top_mask(p - 64) : 64'd0)) == 64'd0;
	endfunction

	function automatic void recompute_path_mtu();
		logic [15:0] m;
		m = sprt_pkg::MtuEmpty;
		if (tbl_locked) return;
		for (int k = 0; k < tbl_count; k++)
			if (tbl_mtu[k] < m) m = tbl_mtu[k];
		tbl_path_mtu = m;
	endfunction

	// Applies one request to the model table and returns the response it causes.
	function automatic sprt_pkg::rsp_t route_outcome(sprt_pkg::req_t r);
		sprt_pkg::rsp_t o;
		int idx;
		o = '0;
		o.status = sprt_pkg::ST_OK;
		idx = r.rule_index;
		case (r.action)
			sprt_pkg::ACT_LOOKUP: begin
				o.status = sprt_pkg::ST_NO_MATCH;
				for (int k = 0; k < tbl_count; k++) begin
					if (rule_hit(k, r.is_ipv6, r.address_high, r.address_low)) begin
						o.status = sprt_pkg::ST_OK;
						o.hit = 1'b1;
						o.matched_index = k[3:0];
						o.matched_port = tbl_port[k];
						break;
					end
				end
			end
			sprt_pkg::ACT_SET: begin
				if (idx > tbl_count) o.status = sprt_pkg::ST_BAD_IDX;
				else if (r.prefix_length > (r.is_ipv6 ? 128 : 32))
					o.status = sprt_pkg::ST_BAD_PLEN;
				else if (idx == tbl_count && tbl_count >= sprt_pkg::MaxRules)
					o.status = sprt_pkg::ST_FULL;
				else begin
					if (idx == tbl_count) tbl_count++;
					tbl_v6[idx] = r.is_ipv6;
					tbl_hi[idx] = r.is_ipv6 ? r.address_high : 64'd0;
					tbl_lo[idx] = r.is_ipv6 ? r.address_low : {32'd0, r.address_low[31:0]};
					tbl_plen[idx] = r.prefix_length;
					tbl_port[idx] = r.dest_port;
					tbl_mtu[idx] = r.dest_mtu;
					recompute_path_mtu();
				end
			end
			sprt_pkg::ACT_DELETE: begin
				if (idx >= tbl_count) o.status = sprt_pkg::ST_BAD_IDX;
				else begin
					for (int k = idx; k + 1 < tbl_count; k++) begin
						tbl_v6[k] = tbl_v6[k + 1];
						tbl_hi[k] = tbl_hi[k + 1];
						tbl_lo[k] = tbl_lo[k + 1];
						tbl_plen[k] = tbl_plen[k + 1];
						tbl_port[k] = tbl_port[k + 1];
						tbl_mtu[k] = tbl_mtu[k + 1];
					end
					tbl_count--;
					recompute_path_mtu();
				end
			end
			default: ;  // the spare action code does nothing
		endcase
		o.rule_count = tbl_count[4:0];
		o.path_mtu = tbl_path_mtu;
		return o;
	endfunction

	function automatic int pick_gap(bit steady);
		int r;
		if (steady) return 0;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// Sends one word. Must be entered right after a rising edge; leaves valid
	// high only when the next word follows at once, so callers that stop
	// sending go through wait_drained.
	task automatic send_word(sprt_pkg::req_t r);
		int gap;
		req.valid <= 1'b1;
		req.data <= r;
		do @(posedge clk); while (!req.ready);
		expected_words.push_back(route_outcome(r));
		gap = pick_gap(steady_source);
		if (gap > 0) begin
			req.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Waits until every expected word has come, then lets the block settle.
	task automatic wait_drained();
		req.valid <= 1'b0;
		@(posedge clk);
		while (expected_words.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_lock(logic value);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= 2'(sprt_pkg::REG_MTU_LOCKED * 4);
		pwdata <= {31'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		tbl_locked = value;
	endtask

	function automatic sprt_pkg::req_t make_word(logic [1:0] action, logic v6, int idx,
			int plen, logic [15:0] mtu);
		sprt_pkg::req_t r;
		r.action = action;
		r.is_ipv6 = v6;
		r.address_high = {$urandom, $urandom};
		r.address_low = {$urandom, $urandom};
		r.rule_index = idx[4:0];
		r.prefix_length = plen[7:0];
		r.dest_port = 8'($urandom_range(0, 255));
		r.dest_mtu = mtu;
		return r;
	endfunction

	// A lookup aimed at rule k: its prefix bits are kept, the rest is random.
	function automatic sprt_pkg::req_t aimed_lookup(int k);
		sprt_pkg::req_t r;
		logic [63:0] mh;
		logic [63:0] ml;
		int p;
		r = make_word(sprt_pkg::ACT_LOOKUP, tbl_v6[k], 0, 0, 16'd0);
		p = tbl_plen[k];
		if (!tbl_v6[k]) begin
			r.address_low[31:0] = (tbl_lo[k][31:0] & v4_mask(p)) |
				(r.address_low[31:0] & ~v4_mask(p));
		end else begin
			mh = top_mask(p);
			ml = p > 64 ? top_mask(p - 64) : 64'd0;
			r.address_high = (tbl_hi[k] & mh) | (r.address_high & ~mh);
			r.address_low = (tbl_lo[k] & ml) | (r.address_low & ~ml);
		end
		return r;
	endfunction

	function automatic sprt_pkg::req_t random_word();
		sprt_pkg::req_t r;
		int sel;
		logic v6;
		int idx;
		int plen;
		sel = $urandom_range(0, 99);
		v6 = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 9) == 0) idx = $urandom_range(0, 31);
		else if (sel < 75) idx = $urandom_range(0, tbl_count);
		else idx = tbl_count > 0 ? $urandom_range(0, tbl_count - 1) : 0;
		if ($urandom_range(0, 9) == 0) plen = $urandom_range(0, 255);
		else plen = $urandom_range(0, v6 ? 128 : 32);
		if (sel < 40) begin
			if (tbl_count > 0 && $urandom_range(0, 3) != 0)
				r = aimed_lookup($urandom_range(0, tbl_count - 1));
			else
				r = make_word(sprt_pkg::ACT_LOOKUP, v6, idx, plen, 16'($urandom));
		end else if (sel < 75) begin
			r = make_word(sprt_pkg::ACT_SET, v6, idx, plen, 16'($urandom));
			// Keep many IPv4 rules clean below the prefix so that they can hit.
			if (!v6 && $urandom_range(0, 2) != 0)
				r.address_low[31:0] = r.address_low[31:0] & v4_mask(plen);
		end else if (sel < 96) begin
			r = make_word(sprt_pkg::ACT_DELETE, v6, idx, plen, 16'($urandom));
		end else begin
			r = make_word(sprt_pkg::ACT_SPARE, v6, idx, plen, 16'($urandom));
		end
		return r;
	endfunction

	// Sink side: ready drops for random stretches, mostly short.
	int stall_left;
	always @(posedge clk) begin
		if (steady_sink) begin
			rsp.ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
		end else if ($urandom_range(0, 9) < 6) begin
			rsp.ready <= 1'b1;
			stall_left <= $urandom_range(0, 15);
		end else begin
			rsp.ready <= 1'b0;
			stall_left <= $urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
				: $urandom_range(0, 3);
		end
	end

	// Each accepted response word is compared with the oldest expectation.
	always @(posedge clk) begin
		sprt_pkg::rsp_t want;
		sprt_pkg::rsp_t got;
		if (arst_n && rsp.valid && rsp.ready) begin
			got = rsp.data;
			if (expected_words.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10) $display("unexpected response word %h", got);
			end else begin
				want = expected_words.pop_front();
				if (got.status !== want.status || got.hit !== want.hit ||
						got.matched_index !== want.matched_index ||
						got.matched_port !== want.matched_port ||
						got.rule_count !== want.rule_count ||
						got.path_mtu !== want.path_mtu) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display({"mismatch: expected st=%0d hit=%0d idx=%0d port=%0d",
							" cnt=%0d mtu=%0d, got st=%0d hit=%0d idx=%0d port=%0d",
							" cnt=%0d mtu=%0d"},
							want.status, want.hit, want.matched_index, want.matched_port,
							want.rule_count, want.path_mtu, got.status, got.hit,
							got.matched_index, got.matched_port, got.rule_count,
							got.path_mtu);
				end
			end
		end
	end

	// Edge cases: empty table, prefix length limits per family, bad index,
	// full table, overwrite, delete shifting, MTU extremes, the spare action.
	task automatic test_directed();
		sprt_pkg::req_t r;
		steady_source = 1;
		send_word(make_word(sprt_pkg::ACT_LOOKUP, 1'b0, 0, 0, 16'd0));
		send_word(make_word(sprt_pkg::ACT_DELETE, 1'b0, 0, 0, 16'd0));
		send_word(make_word(sprt_pkg::ACT_SET, 1'b0, 1, 8, 16'd1500));
		send_word(make_word(sprt_pkg::ACT_SET, 1'b0, 0, 33, 16'd1500));
		send_word(make_word(sprt_pkg::ACT_SET, 1'b1, 0, 129, 16'd1500));
		send_word(make_word(sprt_pkg::ACT_SET, 1'b1, 0, 255, 16'd1500));
		r = make_word(sprt_pkg::ACT_SET, 1'b0, 0, 32, 16'hffff);
		r.address_low = '1;
		send_word(r);
		send_word(aimed_lookup(0));
		r = make_word(sprt_pkg::ACT_SET, 1'b1, 1, 128, 16'd0);
		r.address_high = '1;
		r.address_low = '1;
		r.dest_port = 8'hff;
		send_word(r);
		send_word(aimed_lookup(1));
		send_word(make_word(sprt_pkg::ACT_SET, 1'b1, 2, 0, 16'd9000));
		send_word(make_word(sprt_pkg::ACT_SET, 1'b0, 3, 0, 16'd576));
		send_word(aimed_lookup(2));
		send_word(make_word(sprt_pkg::ACT_SET, 1'b0, 1, 24, 16'd1280));  // overwrite
		send_word(make_word(sprt_pkg::ACT_SPARE, 1'b1, 31, 255, 16'hffff));
		send_word(make_word(sprt_pkg::ACT_DELETE, 1'b0, 0, 0, 16'd0));
		send_word(make_word(sprt_pkg::ACT_DELETE, 1'b0, 31, 0, 16'd0));
		steady_source = 0;
		while (tbl_count < sprt_pkg::MaxRules)
			send_word(make_word(sprt_pkg::ACT_SET, 1'($urandom_range(0, 1)), tbl_count, 0,
				16'($urandom)));
		send_word(make_word(sprt_pkg::ACT_SET, 1'b0, sprt_pkg::MaxRules, 4, 16'd100));
		send_word(make_word(sprt_pkg::ACT_SET, 1'b0, sprt_pkg::MaxRules - 1, 4, 16'd100));
		send_word(make_word(sprt_pkg::ACT_DELETE, 1'b0, sprt_pkg::MaxRules - 1, 0, 16'd0));
		send_word(make_word(sprt_pkg::ACT_DELETE, 1'b0, 0, 0, 16'd0));
		wait_drained();
	endtask

	// With the lock set, sets and deletes leave the path MTU alone; clearing
	// it takes effect at the next successful change.
	task automatic test_mtu_lock();
		write_lock(1'b1);
		send_word(make_word(sprt_pkg::ACT_SET, 1'b0, 0, 16, 16'd0));
		send_word(make_word(sprt_pkg::ACT_DELETE, 1'b0, 0, 0, 16'd0));
		send_word(make_word(sprt_pkg::ACT_SET, 1'b0, tbl_count, 16, 16'd68));
		wait_drained();
		write_lock(1'b0);
		send_word(make_word(sprt_pkg::ACT_LOOKUP, 1'b0, 0, 0, 16'd0));
		send_word(make_word(sprt_pkg::ACT_SET, 1'b1, 0, 64, 16'd1400));
		wait_drained();
	endtask

	task automatic test_random(int n_words);
		for (int phase = 0; phase < 6; phase++) begin
			steady_sink = phase == 2;
			steady_source = phase == 2;
			write_lock(phase == 1 || phase == 4);
			for (int i = 0; i < n_words / 6; i++) begin
				send_word(random_word());
				// Hold off once until everything outstanding has come back.
				if (phase == 3 && i == 100) wait_drained();
			end
			wait_drained();
		end
		steady_sink = 0;
		steady_source = 0;
	endtask

	initial begin
		arst_n = 1'b0;
		req.valid = 1'b0;
		req.data = '0;
		rsp.ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		stall_left = 0;
		steady_sink = 0;
		steady_source = 0;
		n_mismatch = 0;
		tbl_count = 0;
		tbl_path_mtu = sprt_pkg::MtuEmpty;
		tbl_locked = 1'b0;
		for (int k = 0; k < sprt_pkg::MaxRules; k++) begin
			tbl_hi[k] = '0;
			tbl_lo[k] = '0;
			tbl_v6[k] = 1'b0;
			tbl_plen[k] = '0;
			tbl_port[k] = '0;
			tbl_mtu[k] = '0;
		end
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_directed();
		test_mtu_lock();
		test_random(1320);

		if (expected_words.size() != 0) n_mismatch++;
		if (n_mismatch == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

	initial begin
		#(longint'(LimitCycles) * ClkPeriod);
		$display("tb: done, errors");
		$finish;
	end
endmodule
